FILE: design/mao_pkg.sv
// Package with the shared pixel type, register indices and reset values of the overlay block.
`timescale 1ns / 1ps
`default_nettype none

package mao_pkg;

   // Number of colour channels carried by one pixel.
   localparam int unsigned CHANNELS = 4;

   // Width of one channel byte and the full-scale weight.
   localparam int unsigned PIX_W     = 8;
   localparam int unsigned ALPHA_MAX = 255;

   // Width of the geometry registers on the register port.
   localparam int unsigned GEOM_W = 13;
   localparam int unsigned NCH_W  = 3;
   localparam int unsigned CSR_IDX_W = 3;

   typedef logic [PIX_W-1:0] pix_type;

   // Register indices on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH   = 3'd0,
      CSR_OVERLAY_X     = 3'd1,
      CSR_OVERLAY_Y     = 3'd2,
      CSR_FG_WIDTH      = 3'd3,
      CSR_FG_HEIGHT     = 3'd4,
      CSR_USE_MASK      = 3'd5,
      CSR_CHANNEL_COUNT = 3'd6
   } csr_index_type;

   // Reset values of the registers.
   localparam logic [GEOM_W-1:0] FRAME_WIDTH_RST   = 13'd640;
   localparam logic [GEOM_W-1:0] OVERLAY_X_RST     = 13'd0;
   localparam logic [GEOM_W-1:0] OVERLAY_Y_RST     = 13'd0;
   localparam logic [GEOM_W-1:0] FG_WIDTH_RST      = 13'd640;
   localparam logic [GEOM_W-1:0] FG_HEIGHT_RST     = 13'd480;
   localparam logic              USE_MASK_RST      = 1'b0;
   localparam logic [NCH_W-1:0]  CHANNEL_COUNT_RST = 3'd3;

endpackage

`default_nettype wire

FILE: design/masked_alpha_overlay.sv
// Top level of the masked alpha overlay: position tracking, input stage and result register.
//
// Usage. Background pixels stream in on the req_ channel in raster order, one word per
// pixel, each with the aligned foreground pixel and mask byte; req_tuser marks the first
// pixel of a frame and restarts the column and row counters at (0,0). Each accepted word
// gives exactly one result word on the rsp_ channel, in order. Inside the overlay
// rectangle the blended channels become floor((bg*(255-a)+fg*a)/255); elsewhere the
// background passes unchanged, and rsp_tuser reports whether the pixel lay inside.
// An accepted word is held in the input stage and moves into the result register once that
// register is free to take it, where it waits for rsp_tready. Position and weight are settled
// into the input stage, the eight 8 by 8 products and the divide by 255 sit between that
// stage and the result register. Throughput is one word per cycle while the receiver
// takes results; when rsp_tready is low the result register holds its word, the input
// stage fills, and req_tready then falls until the receiver takes a word again.
// The csr_ port is always ready; the user is to write registers only while the stream is idle,
// which the block does not enforce. Synchronous reset empties both stages, clears the counters
// and loads the register defaults (frame width 640, origin 0,0, foreground 640 by 480, alpha
// from foreground channel 3, three channels blended).
`timescale 1ns / 1ps
`default_nettype none

module masked_alpha_overlay import mao_pkg::*; #(
   parameter int MAX_DIM = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input pixels.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,  // bg_c0, bg_c1, bg_c2, bg_c3, fg_c0..fg_c3, mask_value
   input  wire logic        req_tuser,  // start_of_frame
   // Result pixels.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // out_c0, out_c1, out_c2, out_c3
   output logic             rsp_tuser,  // in_overlay
   // Register writes.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [GEOM_W-1:0]    csr_data
);

   // Counter width and widths for the position compares.
   localparam int CW = $clog2(MAX_DIM);
   localparam int WW = (CW + 1 > GEOM_W) ? CW + 1 : GEOM_W;
   localparam int DW = ((CW > GEOM_W) ? CW : GEOM_W) + 2;

   // Configuration registers.
   logic [GEOM_W-1:0] frame_width_ff, overlay_x_ff, overlay_y_ff;
   logic [GEOM_W-1:0] fg_width_ff, fg_height_ff;
   logic              use_mask_ff;
   logic [NCH_W-1:0]  channel_count_ff;

   // Position counters.
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;

   // Input stage.
   logic                 s1_valid_ff, s1_valid_in;
   pix_type              s1_bg_ff    [CHANNELS];
   pix_type              s1_fg_ff    [CHANNELS];
   pix_type              s1_alpha_ff;
   logic                 s1_inside_ff;
   logic [CHANNELS-1:0]  s1_enable_ff;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   pix_type              rsp_pix_ff  [CHANNELS];
   logic                 rsp_inside_ff;

   // Combinational signals.
   logic                 req_accept;
   logic                 out_ready;
   logic                 s1_advance;
   pix_type              in_bg   [CHANNELS];
   pix_type              in_fg   [CHANNELS];
   pix_type              in_mask;
   pix_type              in_alpha;
   logic [CW-1:0]        col_use, row_use;
   logic [WW-1:0]        width_eff;
   logic [WW-1:0]        col_plus;
   logic signed [DW-1:0] dx, dy;
   logic                 inside_x, inside_y, in_rect;
   logic [CHANNELS-1:0]  enable;
   pix_type              blend_pix [CHANNELS];

   // Register port: always ready, writes beyond the list are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= FRAME_WIDTH_RST;
         overlay_x_ff     <= OVERLAY_X_RST;
         overlay_y_ff     <= OVERLAY_Y_RST;
         fg_width_ff      <= FG_WIDTH_RST;
         fg_height_ff     <= FG_HEIGHT_RST;
         use_mask_ff      <= USE_MASK_RST;
         channel_count_ff <= CHANNEL_COUNT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH:   frame_width_ff   <= csr_data;
            CSR_OVERLAY_X:     overlay_x_ff     <= csr_data;
            CSR_OVERLAY_Y:     overlay_y_ff     <= csr_data;
            CSR_FG_WIDTH:      fg_width_ff      <= csr_data;
            CSR_FG_HEIGHT:     fg_height_ff     <= csr_data;
            CSR_USE_MASK:      use_mask_ff      <= csr_data[0];
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_data[NCH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Handshake: the stages move together whenever the result register can take a word.
   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign s1_advance = out_ready;
   assign req_tready = !s1_valid_ff || out_ready;
   assign req_accept = req_tvalid && req_tready;

   // Unpack the input word.
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         in_bg[c] = req_tdata[c*PIX_W +: PIX_W];
         in_fg[c] = req_tdata[(CHANNELS + c)*PIX_W +: PIX_W];
      end
   end
   assign in_mask  = req_tdata[2*CHANNELS*PIX_W +: PIX_W];
   assign in_alpha = use_mask_ff ? in_mask : in_fg[CHANNELS-1];

   // Position of this pixel: a start of frame puts it at the origin.
   assign col_use = req_tuser ? '0 : col_ff;
   assign row_use = req_tuser ? '0 : row_ff;

   // Inside test against the rectangle, with the origin sign-extended.
   assign dx = $signed({{(DW-CW){1'b0}}, col_use})
             - $signed({{(DW-GEOM_W){overlay_x_ff[GEOM_W-1]}}, overlay_x_ff});
   assign dy = $signed({{(DW-CW){1'b0}}, row_use})
             - $signed({{(DW-GEOM_W){overlay_y_ff[GEOM_W-1]}}, overlay_y_ff});
   assign inside_x = !dx[DW-1] && (dx[DW-2:0] < {{(DW-1-GEOM_W){1'b0}}, fg_width_ff});
   assign inside_y = !dy[DW-1] && (dy[DW-2:0] < {{(DW-1-GEOM_W){1'b0}}, fg_height_ff});
   assign in_rect  = inside_x && inside_y;

   // Channels below the channel count are blended; a count above four covers all four.
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         enable[c] = in_rect && (channel_count_ff > NCH_W'(c));
      end
   end

   // Row length: zero or anything above the counter range means the full range.
   assign width_eff = (frame_width_ff == '0 ||
                       WW'(frame_width_ff) > WW'(MAX_DIM)) ? WW'(MAX_DIM)
                                                           : WW'(frame_width_ff);
   assign col_plus  = WW'(col_use) + WW'(1);

   // Counter advance for the next pixel.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (col_plus >= width_eff) begin
            col_in = '0;
            row_in = (row_use == CW'(MAX_DIM - 1)) ? '0 : row_use + CW'(1);
         end else begin
            col_in = col_plus[CW-1:0];
            row_in = row_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Input stage valid flag.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Input stage payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         for (int c = 0; c < CHANNELS; c++) begin
            s1_bg_ff[c] <= in_bg[c];
            s1_fg_ff[c] <= in_fg[c];
         end
         s1_alpha_ff  <= in_alpha;
         s1_inside_ff <= in_rect;
         s1_enable_ff <= enable;
      end
   end

   // Blend arithmetic, one unit per channel.
   for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
      mao_blend u_blend (
         .bg     (s1_bg_ff[g]),
         .fg     (s1_fg_ff[g]),
         .alpha  (s1_alpha_ff),
         .enable (s1_enable_ff[g]),
         .result (blend_pix[g])
      );
   end

   // Result register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_ready) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (out_ready && s1_valid_ff) begin
         for (int c = 0; c < CHANNELS; c++) begin
            rsp_pix_ff[c] <= blend_pix[c];
         end
         rsp_inside_ff <= s1_inside_ff;
      end
   end

   // Output packing.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_inside_ff;
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         rsp_tdata[c*PIX_W +: PIX_W] = rsp_pix_ff[c];
      end
   end

endmodule

`default_nettype wire

FILE: design/mao_blend.sv
// One channel of the blend: floor((bg*(255-a) + fg*a) / 255), or bg passed through.
`timescale 1ns / 1ps
`default_nettype none

module mao_blend import mao_pkg::*; (
   input  wire pix_type bg,
   input  wire pix_type fg,
   input  wire pix_type alpha,
   input  wire logic    enable,
   output pix_type      result
);

   logic [PIX_W-1:0]     inv_alpha;
   logic [2*PIX_W-1:0]   bg_prod;
   logic [2*PIX_W-1:0]   fg_prod;
   logic [2*PIX_W:0]     mix_sum;
   logic [2*PIX_W:0]     quot_sum;

   // Weighted sum of the two pixels; it stays at or below 255*255.
   assign inv_alpha = PIX_W'(ALPHA_MAX) - alpha;
   assign bg_prod   = bg * inv_alpha;
   assign fg_prod   = fg * alpha;
   assign mix_sum   = {1'b0, bg_prod} + {1'b0, fg_prod};

   // Exact floor division by 255 for sums below 65535: (s + (s >> 8) + 1) >> 8.
   assign quot_sum = mix_sum + (mix_sum >> PIX_W) + (2*PIX_W+1)'(1);

   assign result = enable ? quot_sum[2*PIX_W-1:PIX_W] : bg;

endmodule

`default_nettype wire

FILE: design/mao_checker.sv
// Port-level checks for the overlay block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module mao_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   // Reset leaves both stages empty and the input open.
   assert property (@(posedge clock) reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   // With no result waiting the block must take input.
   assert property (@(posedge clock) disable iff (reset) !rsp_tvalid |-> req_tready)
      else $error("input stalled while the result register is empty");

   // A word taken in appears at the output once the result register has been free to take it.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 (!rsp_tvalid || rsp_tready) |=> rsp_tvalid)
      else $error("accepted word lost on its way to the output");

   // A stalled result holds its word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind masked_alpha_overlay mao_checker u_mao_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

FILE: sim/masked_alpha_overlay_tb.sv
// Self-checking testbench for the masked alpha overlay: directed plan, random phases, scoreboard.
`timescale 1ns / 1ps

module masked_alpha_overlay_tb;
   import mao_pkg::*;

   localparam int MAX_DIM      = 4096;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_WORDS = 1080;
   localparam int PRINT_LIMIT  = 40;

   // One result word: four channel bytes and the overlay flag.
   typedef struct packed {
      logic                       in_overlay;
      pix_type [CHANNELS-1:0]     chan;
   } result_word_type;

   // Expectation that a directed row may carry in place of the prediction.
   typedef struct packed {
      logic            typed;
      result_word_type value;
   } fixed_result_type;

   typedef enum logic {ROW_PIXEL, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {RX_OPEN, RX_TOGGLE, RX_RANDOM, RX_LONG_STALL} rx_mode_type;

   // One row of the directed plan: either a register write or a pixel word.
   typedef struct {
      row_kind_type      kind;
      csr_index_type     index;
      logic [GEOM_W-1:0] value;
      logic              sof;
      logic [71:0]       data;
      fixed_result_type  fixed;
   } plan_row_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [71:0] req_tdata;   // bg_c0..bg_c3, fg_c0..fg_c3, mask_value
   logic req_tuser;          // start_of_frame
   logic rsp_tvalid;
   logic rsp_tready;
   logic [31:0] rsp_tdata;   // out_c0..out_c3
   logic rsp_tuser;          // in_overlay
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [GEOM_W-1:0] csr_data;

   // Register shadow and position counters of the predictor.
   logic [GEOM_W-1:0] cfg_frame_width;
   logic [GEOM_W-1:0] cfg_overlay_x;
   logic [GEOM_W-1:0] cfg_overlay_y;
   logic [GEOM_W-1:0] cfg_fg_width;
   logic [GEOM_W-1:0] cfg_fg_height;
   logic              cfg_use_mask;
   logic [NCH_W-1:0]  cfg_channel_count;
   int col_pos;
   int row_pos;

   result_word_type  pending_pixels[$];
   fixed_result_type fixed_results[$];
   plan_row_type     directed_plan[$];

   int mismatch_count;
   int words_accepted;
   int results_checked;
   int overlay_hits;
   int csr_writes;
   int phase_count;
   int random_words;
   int directed_words;
   int cycle_count;
   int burst_left;
   bit steady;

   rx_mode_type rx_mode;
   int rx_cycle;
   int stall_left;

   masked_alpha_overlay #(.MAX_DIM(MAX_DIM)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Clock with a 10 ns period.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Works out the result word for one pixel and advances the position counters.
   function automatic result_word_type overlay_predict(input logic sof, input logic [71:0] data);
      result_word_type res;
      int dx;
      int dy;
      int fg_w;
      int fg_h;
      int lanes;
      int span;
      int unsigned weight;
      int unsigned bg;
      int unsigned fg;
      logic hit;
      weight = cfg_use_mask ? 32'(data[71:64]) : 32'(data[63:56]);
      if (sof) begin
         col_pos = 0;
         row_pos = 0;
      end
      fg_w = 32'(cfg_fg_width);
      fg_h = 32'(cfg_fg_height);
      dx = col_pos - $signed(cfg_overlay_x);
      dy = row_pos - $signed(cfg_overlay_y);
      hit = dx >= 0 && dy >= 0 && dx < fg_w && dy < fg_h;
      lanes = (cfg_channel_count > 4) ? 4 : 32'(cfg_channel_count);
      for (int c = 0; c < CHANNELS; c++) begin
         bg = 32'(data[8*c +: 8]);
         fg = 32'(data[32 + 8*c +: 8]);
         if (hit && c < lanes) begin
            res.chan[c] = 8'((bg * (ALPHA_MAX - weight) + fg * weight) / ALPHA_MAX);
         end else begin
            res.chan[c] = 8'(bg);
         end
      end
      res.in_overlay = hit;
      // A width of zero or beyond the maximum behaves as the maximum.
      span = (cfg_frame_width == 0 || cfg_frame_width > MAX_DIM) ? MAX_DIM
                                                                 : 32'(cfg_frame_width);
      if (col_pos + 1 >= span) begin
         col_pos = 0;
         row_pos = (row_pos + 1) % MAX_DIM;
      end else begin
         col_pos = col_pos + 1;
      end
      return res;
   endfunction

   // Prints one mismatch line (up to a limit) and counts it.
   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("ERROR at %0t ns: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
      end
      mismatch_count++;
   endtask

   // Register writes, predictions on accepted words and checks on result words.
   always @(posedge clock) begin
      result_word_type  got;
      result_word_type  want;
      fixed_result_type fixed;
      if (reset) begin
         cfg_frame_width   = FRAME_WIDTH_RST;
         cfg_overlay_x     = OVERLAY_X_RST;
         cfg_overlay_y     = OVERLAY_Y_RST;
         cfg_fg_width      = FG_WIDTH_RST;
         cfg_fg_height     = FG_HEIGHT_RST;
         cfg_use_mask      = USE_MASK_RST;
         cfg_channel_count = CHANNEL_COUNT_RST;
         col_pos = 0;
         row_pos = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            csr_writes++;
            case (csr_index_type'(csr_index))
               CSR_FRAME_WIDTH:   cfg_frame_width   = csr_data;
               CSR_OVERLAY_X:     cfg_overlay_x     = csr_data;
               CSR_OVERLAY_Y:     cfg_overlay_y     = csr_data;
               CSR_FG_WIDTH:      cfg_fg_width      = csr_data;
               CSR_FG_HEIGHT:     cfg_fg_height     = csr_data;
               CSR_USE_MASK:      cfg_use_mask      = csr_data[0];
               CSR_CHANNEL_COUNT: cfg_channel_count = csr_data[NCH_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            words_accepted++;
            want = overlay_predict(req_tuser, req_tdata);
            fixed = '0;
            if (fixed_results.size() != 0) begin
               fixed = fixed_results.pop_front();
            end
            if (fixed.typed) begin
               want = fixed.value;
            end
            if (want.in_overlay) begin
               overlay_hits++;
            end
            pending_pixels.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.chan       = rsp_tdata;
            got.in_overlay = rsp_tuser;
            if (pending_pixels.size() == 0) begin
               report_mismatch("result word with none outstanding", 0, got.chan);
            end else begin
               want = pending_pixels.pop_front();
               results_checked++;
               for (int c = 0; c < CHANNELS; c++) begin
                  if (got.chan[c] !== want.chan[c]) begin
                     report_mismatch($sformatf("out_c%0d", c), want.chan[c], got.chan[c]);
                  end
               end
               if (got.in_overlay !== want.in_overlay) begin
                  report_mismatch("in_overlay", want.in_overlay, got.in_overlay);
               end
            end
         end
      end
   end

   // Receiver readiness: follows one of its own stall patterns, chosen anew at random.
   always @(negedge clock) begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
      end
      if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else begin
         case (rx_mode)
            RX_OPEN:   rsp_tready = 1'b1;
            RX_TOGGLE: rsp_tready = ~rsp_tready;
            RX_RANDOM: rsp_tready = ($urandom_range(0, 3) != 0);
            default: begin
               if ($urandom_range(0, 9) == 0) begin
                  stall_left = $urandom_range(1, 12);
                  rsp_tready = 1'b0;
               end else begin
                  rsp_tready = 1'b1;
               end
            end
         endcase
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_pixels.size());
         $display("masked_alpha_overlay regression: fail");
         $finish;
      end
   end

   // Sends one pixel word, opening a new burst with a random gap where one has run out.
   task automatic send_pixel(input logic sof, input logic [71:0] data,
                             input fixed_result_type fixed);
      int gap;
      if (burst_left == 0) begin
         gap = steady ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      fixed_results.push_back(fixed);
      req_tvalid = 1'b1;
      req_tdata  = data;
      req_tuser  = sof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   // Stops the stream and waits until every expected word has come back.
   task automatic drain();
      req_tvalid = 1'b0;
      burst_left = 0;
      while (pending_pixels.size() != 0) @(negedge clock);
   endtask

   // Writes one register over the configuration channel.
   task automatic write_csr(input csr_index_type index, input logic [GEOM_W-1:0] value);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic void add_csr(input csr_index_type index, input logic [GEOM_W-1:0] value);
      plan_row_type row;
      row = '{kind: ROW_CSR, index: index, value: value, sof: 1'b0, data: '0, fixed: '0};
      directed_plan.push_back(row);
   endfunction

   // Pixel row; bg and fg are packed with channel 0 in the low byte.
   function automatic void add_pix(input logic sof, input logic [31:0] bg, input logic [31:0] fg,
                                   input logic [7:0] mask, input logic typed,
                                   input logic [31:0] out, input logic hit);
      plan_row_type row;
      row.kind  = ROW_PIXEL;
      row.index = CSR_FRAME_WIDTH;
      row.value = '0;
      row.sof   = sof;
      row.data  = {mask, fg, bg};
      row.fixed = '{typed: typed, value: '{in_overlay: hit, chan: out}};
      directed_plan.push_back(row);
   endfunction

   // Random pixel word with the weight bytes often at their extremes.
   function automatic logic [71:0] random_word();
      logic [71:0] data;
      data = 72'({$urandom, $urandom, $urandom});
      case ($urandom_range(0, 7))
         0: data[71:64] = 8'h00;
         1: data[71:64] = 8'hFF;
         2: data[63:56] = 8'h00;
         3: data[63:56] = 8'hFF;
         default: ;
      endcase
      return data;
   endfunction

   // Geometry value for the random phases: mostly small, sometimes an extreme.
   function automatic logic [GEOM_W-1:0] random_extent();
      case ($urandom_range(0, 9))
         0: return 13'd0;
         1: return 13'h1000;   // 4096
         2: return GEOM_W'($urandom);
         default: return GEOM_W'($urandom_range(1, 24));
      endcase
   endfunction

   function automatic logic [GEOM_W-1:0] random_origin();
      case ($urandom_range(0, 9))
         0: return 13'h1000;   // -4096
         1: return 13'h0FFF;   // 4095
         2: return GEOM_W'($urandom);
         default: return GEOM_W'($urandom_range(0, 40) - 8);
      endcase
   endfunction

   initial begin
      int words;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      rx_mode    = RX_OPEN;
      rx_cycle   = 0;
      stall_left = 0;
      burst_left = 0;
      steady     = 1'b0;
      cycle_count = 0;

      // Directed plan, starting from the reset settings (640 wide, 3 channels, alpha from fg_c3).
      add_pix(1, 32'h44332211, 32'hFFCCBBAA, 8'h00, 1, 32'h44CCBBAA, 1);  // full weight
      add_pix(0, 32'hFFFFFFFF, 32'h00563412, 8'hFF, 1, 32'hFFFFFFFF, 1);  // zero weight
      add_pix(0, 32'h00000000, 32'hFFFFFFFF, 8'h00, 1, 32'h00FFFFFF, 1);
      add_pix(0, 32'h9C7F4001, 32'h80FE01FF, 8'h00, 0, '0, 0);
      add_csr(CSR_USE_MASK, 13'd1);
      add_pix(0, 32'h00000000, 32'h00FFFFFF, 8'hFF, 1, 32'h00FFFFFF, 1);
      add_pix(0, 32'hC33CA55A, 32'hFFFFFFFF, 8'h00, 1, 32'hC33CA55A, 1);
      // Four channels with the weight from fg_c3: the alpha channel blends with itself.
      add_csr(CSR_CHANNEL_COUNT, 13'd4);
      add_csr(CSR_USE_MASK, 13'd0);
      add_pix(0, 32'h40302010, 32'hFF706050, 8'h00, 1, 32'hFF706050, 1);
      add_pix(0, 32'h00112233, 32'h7FD0E0F0, 8'hFF, 0, '0, 0);
      // No channels blended, yet the flag is still reported.
      add_csr(CSR_CHANNEL_COUNT, 13'd0);
      add_pix(0, 32'h04030201, 32'hFFFFFFFF, 8'h00, 1, 32'h04030201, 1);
      // A channel count above four behaves as four.
      add_csr(CSR_CHANNEL_COUNT, 13'd7);
      add_pix(0, 32'h00000000, 32'hFF706050, 8'h00, 1, 32'hFF706050, 1);
      // Origin at the extremes of its range.
      add_csr(CSR_OVERLAY_X, 13'h1000);
      add_csr(CSR_OVERLAY_Y, 13'h0FFF);
      add_pix(1, 32'h87654321, 32'hFFFFFFFF, 8'hFF, 1, 32'h87654321, 0);
      add_csr(CSR_OVERLAY_X, 13'h0FFF);
      add_csr(CSR_OVERLAY_Y, 13'h1000);
      add_pix(1, 32'h87654321, 32'hFFFFFFFF, 8'hFF, 1, 32'h87654321, 0);
      // Empty foreground in either direction.
      add_csr(CSR_OVERLAY_X, 13'd0);
      add_csr(CSR_OVERLAY_Y, 13'd0);
      add_csr(CSR_FG_WIDTH, 13'd0);
      add_pix(1, 32'h0FF00FF0, 32'hF00FF00F, 8'h80, 1, 32'h0FF00FF0, 0);
      add_csr(CSR_FG_WIDTH, 13'h1000);
      add_csr(CSR_FG_HEIGHT, 13'd0);
      add_pix(1, 32'h0FF00FF0, 32'hF00FF00F, 8'h80, 1, 32'h0FF00FF0, 0);
      // One column wide foreground; a frame width of zero acts as the maximum.
      add_csr(CSR_FG_HEIGHT, 13'h1000);
      add_csr(CSR_FG_WIDTH, 13'd1);
      add_csr(CSR_FRAME_WIDTH, 13'd0);
      add_pix(1, 32'h12345678, 32'h80ABCDEF, 8'h00, 0, '0, 0);
      add_pix(0, 32'h11223344, 32'hFFFFFFFF, 8'h00, 1, 32'h11223344, 0);
      add_csr(CSR_FRAME_WIDTH, 13'h1FFF);
      add_pix(0, 32'hA1B2C3D4, 32'h5E6F7A8B, 8'h33, 0, '0, 0);
      // Width shrunk below the current column: the column wraps after this word.
      add_csr(CSR_FRAME_WIDTH, 13'd2);
      add_pix(0, 32'h55AA55AA, 32'hAA55AA55, 8'h00, 1, 32'h55AA55AA, 0);
      add_pix(0, 32'hDEADBEEF, 32'h4080C0FF, 8'h00, 0, '0, 0);
      add_csr(CSR_FRAME_WIDTH, 13'd1);
      add_pix(0, 32'h01020304, 32'hFEFDFCFB, 8'h00, 0, '0, 0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_CSR) begin
            drain();
            write_csr(directed_plan[i].index, directed_plan[i].value);
         end else begin
            send_pixel(directed_plan[i].sof, directed_plan[i].data, directed_plan[i].fixed);
            directed_words++;
         end
      end

      // Random phases, each with fresh settings for every register.
      while (random_words < RANDOM_WORDS) begin
         drain();
         phase_count++;
         steady = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0: write_csr(CSR_FRAME_WIDTH, 13'd0);
            1: write_csr(CSR_FRAME_WIDTH, 13'd1);
            2: write_csr(CSR_FRAME_WIDTH, 13'h1000);
            3: write_csr(CSR_FRAME_WIDTH, GEOM_W'($urandom));
            default: write_csr(CSR_FRAME_WIDTH, GEOM_W'($urandom_range(2, 40)));
         endcase
         write_csr(CSR_OVERLAY_X, random_origin());
         write_csr(CSR_OVERLAY_Y, random_origin());
         write_csr(CSR_FG_WIDTH, random_extent());
         write_csr(CSR_FG_HEIGHT, random_extent());
         write_csr(CSR_USE_MASK, GEOM_W'($urandom));
         write_csr(CSR_CHANNEL_COUNT, GEOM_W'($urandom));
         words = $urandom_range(20, 90);
         for (int i = 0; i < words; i++) begin
            // Usually a fresh frame at the start of a phase, now and then one mid-phase.
            send_pixel((i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 49) == 0),
                       random_word(), '0);
            random_words++;
         end
      end

      drain();
      repeat (8) @(negedge clock);
      if (pending_pixels.size() != 0) begin
         report_mismatch("results still outstanding", 0, pending_pixels.size());
      end
      $display("Ran %0d pixel words (%0d directed, %0d random), %0d inside the overlay.",
               words_accepted, directed_words, random_words, overlay_hits);
      $display("Checked %0d results over %0d random setting phases and %0d register writes.",
               results_checked, phase_count, csr_writes);
      if (mismatch_count == 0) begin
         $display("masked_alpha_overlay regression: pass");
      end else begin
         $display("masked_alpha_overlay regression: fail");
      end
      $finish;
   end

endmodule
